/* rtl/lcs_pkg.sv */
// shared types, constants and tables for the lane center steering block
package lcs_pkg;

    localparam int X_W    = 11;
    localparam int Y_W    = 10;
    localparam int SUM_W  = 15;
    localparam int CNT_W  = 5;
    localparam int DIV_W  = 21;
    localparam int DVS_W  = 5;
    localparam int CX_W   = 35;
    localparam int ACC_W  = 26;
    localparam int DIFF_W = 28;

    localparam logic [2:0] CFG_WIDTH_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_LIMIT = 3'd1;
    localparam logic [2:0] CFG_BOTTOM_COUNT = 3'd2;
    localparam logic [2:0] CFG_MAX_LINEAR   = 3'd3;
    localparam logic [2:0] CFG_MAX_ANGULAR  = 3'd4;
    localparam logic [2:0] CFG_STEER_GAIN   = 3'd5;

    localparam logic signed [ACC_W-1:0]  NINETY_Q16 = 26'sd5898240;
    localparam logic signed [DIFF_W-1:0] HEAD_SAT   = 28'sd23040;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } pt_t;

    typedef struct packed {
        logic [10:0] width_limit;
        logic [9:0]  height_limit;
        logic [4:0]  bottom_count;
        logic [14:0] max_linear;
        logic [14:0] max_angular;
        logic [15:0] steer_gain;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [Y_W-1:0]   ylast;
        logic [CNT_W-1:0] bottom;
    } calc_req_t;

    // arctangent of 2^-i in degrees, Q.16
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/lcs_ifs.sv */
// request channel interfaces for lane points and steering results
interface lcs_in_if;
    logic              valid;
    logic              ready;
    logic              lane_side;
    logic signed [11:0] point_x;
    logic [9:0]        point_y;
    logic              frame_last;

    modport source (output valid, lane_side, point_x, point_y, frame_last, input ready);
    modport sink   (input valid, lane_side, point_x, point_y, frame_last, output ready);
endinterface

interface lcs_out_if;
    logic               valid;
    logic               ready;
    logic [14:0]        linear_drive;
    logic signed [15:0] angular_drive;
    logic signed [15:0] heading_error;
    logic [10:0]        center_x;
    logic [4:0]         points_used;

    modport source (output valid, linear_drive, angular_drive, heading_error, center_x,
                    points_used, input ready);
    modport sink   (input valid, linear_drive, angular_drive, heading_error, center_x,
                    points_used, output ready);
endinterface

/* rtl/lcs_ram.sv */
// generic single write, single read ram with registered read data
module lcs_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/lcs_div.sv */
// restoring divider, one quotient bit per cycle
module lcs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcs_pkg::DIV_W-1:0]     dividend,
    input  logic [lcs_pkg::DVS_W-1:0]     divisor,
    output logic                          done,
    output logic [lcs_pkg::DIV_W-1:0]     quotient
);

    localparam int CW = $clog2(lcs_pkg::DIV_W);

    logic [lcs_pkg::DIV_W-1:0] q_reg, q_next;
    logic [lcs_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [lcs_pkg::DVS_W-1:0] d_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic [lcs_pkg::DVS_W:0]   part;
    logic [lcs_pkg::DVS_W:0]   sub;
    logic                      ge;

    always_comb
    begin
        part     = {rem_reg, q_reg[lcs_pkg::DIV_W-1]};
        sub      = part - {1'b0, d_reg};
        ge       = part >= {1'b0, d_reg};
        rem_next = ge ? sub[lcs_pkg::DVS_W-1:0] : part[lcs_pkg::DVS_W-1:0];
        q_next   = {q_reg[lcs_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(lcs_pkg::DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/lcs_lane.sv */
// one lane point store with an in-place insertion sort by descending y
module lcs_lane #(
    parameter int MAX_POINTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
    input  lcs_pkg::pt_t                    wr_data,
    input  logic                            start,
    input  logic [$clog2(MAX_POINTS+1)-1:0] count,
    output logic                            busy,
    input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
    output lcs_pkg::pt_t                    rd_data
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KEY  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] n_reg, n_next;
    lcs_pkg::pt_t key_reg, key_next;

    logic          s_we;
    logic [CW-1:0] s_waddr;
    lcs_pkg::pt_t  s_wdata;
    logic [CW-1:0] s_raddr;
    logic [CW-1:0] i_inc;
    lcs_pkg::pt_t  q;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    lcs_pkg::pt_t  ram_wdata;
    logic [IW-1:0] ram_raddr;

    assign busy = state_reg != S_IDLE;
    assign i_inc = i_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        key_next   = key_reg;
        s_we       = 1'b0;
        s_waddr    = j_reg;
        s_wdata    = key_reg;
        s_raddr    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && count >= CW'(2))
                begin
                    n_next     = count;
                    i_next     = CW'(1);
                    s_raddr    = CW'(1);
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                key_next   = q;
                j_next     = i_reg;
                s_raddr    = i_reg - 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                s_we = 1'b1;
                if (q.y < key_reg.y)
                begin
                    s_wdata = q;
                    j_next  = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        s_raddr = j_reg - CW'(2);
                    end
                end
                else
                begin
                    // key settles here, move to the next element
                    if (i_inc == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        s_raddr    = i_inc;
                        state_next = S_KEY;
                    end
                end
            end
            S_PUT:
            begin
                s_we    = 1'b1;
                s_waddr = '0;
                if (i_inc == n_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_inc;
                    s_raddr    = i_inc;
                    state_next = S_KEY;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        n_reg   <= n_next;
        key_reg <= key_next;
    end

    always_comb
    begin
        if (busy || (start && count >= CW'(2)))
        begin
            ram_we    = s_we;
            ram_waddr = s_waddr[IW-1:0];
            ram_wdata = s_wdata;
            ram_raddr = s_raddr[IW-1:0];
        end
        else
        begin
            ram_we    = wr_en;
            ram_waddr = wr_addr;
            ram_wdata = wr_data;
            ram_raddr = rd_addr;
        end
    end

    lcs_ram #(
        .WIDTH ($bits(lcs_pkg::pt_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (q)
    );

    assign rd_data = q;

endmodule

/* rtl/lcs_calc.sv */
// frame math: mean, cordic heading, drive commands and result register
module lcs_calc #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lcs_pkg::calc_req_t req,
    input  lcs_pkg::cfg_t     cfg,
    output logic              busy,
    lcs_out_if.source         out_ch
);

    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [3:0] C_IDLE = 4'd0;
    localparam logic [3:0] C_MEAN = 4'd1;
    localparam logic [3:0] C_PRE  = 4'd2;
    localparam logic [3:0] C_ITER = 4'd3;
    localparam logic [3:0] C_HEAD = 4'd4;
    localparam logic [3:0] C_MUL1 = 4'd5;
    localparam logic [3:0] C_MUL2 = 4'd6;
    localparam logic [3:0] C_DIVS = 4'd7;
    localparam logic [3:0] C_LIN  = 4'd8;
    localparam logic [3:0] C_HOLD = 4'd9;

    logic [3:0]                     state_reg, state_next;
    lcs_pkg::calc_req_t             req_reg;
    logic [10:0]                    mean_reg;
    logic signed [lcs_pkg::CX_W-1:0]  x_reg, x_next;
    logic signed [lcs_pkg::CX_W-1:0]  y_reg, y_next;
    logic signed [lcs_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [SW-1:0]                  it_reg;
    logic signed [15:0]             head_reg;
    logic [20:0]                    kd_reg;
    logic [19:0]                    m1_reg;
    logic [34:0]                    m2_reg;
    logic [35:0]                    aprod_reg;
    logic [14:0]                    lin_reg;
    logic signed [15:0]             ang_reg, ang_next;
    logic                           valid_reg;

    logic                           div_start;
    logic [lcs_pkg::DIV_W-1:0]      div_a;
    logic [lcs_pkg::DVS_W-1:0]      div_b;
    logic                           div_done;
    logic [lcs_pkg::DIV_W-1:0]      div_q;

    logic signed [11:0]             dx;
    logic signed [10:0]             dy;
    logic signed [lcs_pkg::CX_W-1:0]  xs, ys;
    logic signed [lcs_pkg::ACC_W-1:0] at;
    logic signed [lcs_pkg::DIFF_W-1:0] diff, rnd;
    logic signed [lcs_pkg::DIFF_W-1:0] hsat;
    logic [15:0]                    habs;
    logic [30:0]                    kprod;
    logic [14:0]                    one_minus;
    logic [21:0]                    aabs;

    assign busy = state_reg != C_IDLE;

    always_comb
    begin
        dx = $signed({1'b0, mean_reg}) - $signed({2'b00, cfg.width_limit[10:1]});
        dy = $signed({1'b0, cfg.height_limit}) - $signed({1'b0, req_reg.ylast});
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        at = $signed({{(lcs_pkg::ACC_W-22){1'b0}}, lcs_pkg::atan_q16(5'(it_reg))});
        diff = $signed({{(lcs_pkg::DIFF_W-lcs_pkg::ACC_W){acc_reg[lcs_pkg::ACC_W-1]}}, acc_reg})
               - $signed({{(lcs_pkg::DIFF_W-lcs_pkg::ACC_W){1'b0}}, lcs_pkg::NINETY_Q16});
        rnd  = (diff + lcs_pkg::DIFF_W'(128)) >>> 8;
        if (rnd > lcs_pkg::HEAD_SAT)
        begin
            hsat = lcs_pkg::HEAD_SAT;
        end
        else if (rnd < -lcs_pkg::HEAD_SAT)
        begin
            hsat = -lcs_pkg::HEAD_SAT;
        end
        else
        begin
            hsat = rnd;
        end
        habs      = head_reg[15] ? 16'(-head_reg) : head_reg;
        kprod     = 31'(cfg.steer_gain * habs[14:0]);
        one_minus = 15'(15'd16384 - kd_reg[14:0]);
        aabs      = aprod_reg[35:14];
        if (head_reg > 16'sd0)
        begin
            ang_next = (aabs > 22'd32767) ? 16'sd32767 : $signed(aabs[15:0]);
        end
        else if (head_reg < 16'sd0)
        begin
            ang_next = (aabs > 22'd32768) ? -16'sd32768 : $signed(16'd0 - aabs[15:0]);
        end
        else
        begin
            ang_next = 16'sd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        div_start  = 1'b0;
        div_a      = lcs_pkg::DIV_W'(req.sum);
        div_b      = req.cnt;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    div_start  = 1'b1;
                    state_next = C_MEAN;
                end
            end
            C_MEAN:
            begin
                if (div_done)
                begin
                    state_next = C_PRE;
                end
            end
            C_PRE:
            begin
                x_next   = $signed({{(lcs_pkg::CX_W-32){dx[11]}}, dx, 20'd0});
                y_next   = $signed({{(lcs_pkg::CX_W-31){dy[10]}}, dy, 20'd0});
                acc_next = '0;
                // left half plane: turn by a quarter first
                if (dx < 12'sd0)
                begin
                    if (dy >= 11'sd0)
                    begin
                        x_next   = $signed({{(lcs_pkg::CX_W-31){dy[10]}}, dy, 20'd0});
                        y_next   = -$signed({{(lcs_pkg::CX_W-32){dx[11]}}, dx, 20'd0});
                        acc_next = lcs_pkg::NINETY_Q16;
                    end
                    else
                    begin
                        x_next   = -$signed({{(lcs_pkg::CX_W-31){dy[10]}}, dy, 20'd0});
                        y_next   = $signed({{(lcs_pkg::CX_W-32){dx[11]}}, dx, 20'd0});
                        acc_next = -lcs_pkg::NINETY_Q16;
                    end
                end
                state_next = (dx == 12'sd0 && dy == 11'sd0) ? C_HEAD : C_ITER;
            end
            C_ITER:
            begin
                if (!y_reg[lcs_pkg::CX_W-1])
                begin
                    x_next   = x_reg + ys;
                    y_next   = y_reg - xs;
                    acc_next = acc_reg + at;
                end
                else
                begin
                    x_next   = x_reg - ys;
                    y_next   = y_reg + xs;
                    acc_next = acc_reg - at;
                end
                if (it_reg == SW'(CORDIC_STEPS - 1))
                begin
                    state_next = C_HEAD;
                end
            end
            C_HEAD:
            begin
                state_next = C_MUL1;
            end
            C_MUL1:
            begin
                state_next = C_MUL2;
            end
            C_MUL2:
            begin
                state_next = C_DIVS;
            end
            C_DIVS:
            begin
                div_start  = 1'b1;
                div_a      = m2_reg[34:14];
                div_b      = req_reg.bottom;
                state_next = C_LIN;
            end
            C_LIN:
            begin
                if (div_done)
                begin
                    state_next = C_HOLD;
                end
            end
            C_HOLD:
            begin
                if (out_ch.ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == C_LIN && div_done)
            begin
                valid_reg <= 1'b1;
            end
            else if (state_reg == C_HOLD && out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        if (state_reg == C_IDLE && start)
        begin
            req_reg <= req;
        end
        if (state_reg == C_MEAN && div_done)
        begin
            mean_reg <= div_q[10:0];
        end
        if (state_reg == C_PRE)
        begin
            it_reg <= '0;
        end
        else if (state_reg == C_ITER)
        begin
            it_reg <= it_reg + 1'b1;
        end
        if (state_reg == C_HEAD)
        begin
            head_reg <= hsat[15:0];
        end
        if (state_reg == C_MUL1)
        begin
            kd_reg <= kprod[30:10];
            m1_reg <= 20'(req_reg.cnt * cfg.max_linear);
        end
        if (state_reg == C_MUL2)
        begin
            m2_reg    <= 35'(m1_reg * one_minus);
            aprod_reg <= 36'(cfg.max_angular * kd_reg);
        end
        if (state_reg == C_DIVS)
        begin
            ang_reg <= ang_next;
        end
        if (state_reg == C_LIN && div_done)
        begin
            lin_reg <= (kd_reg >= 21'd16384) ? 15'd0 : div_q[14:0];
        end
    end

    lcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_ch.valid         = valid_reg;
    assign out_ch.linear_drive  = lin_reg;
    assign out_ch.angular_drive = ang_reg;
    assign out_ch.heading_error = head_reg;
    assign out_ch.center_x      = mean_reg;
    assign out_ch.points_used   = req_reg.cnt;

endmodule

/* rtl/lane_center_steering_core.sv */
// lane center steering: point stores, sort, merge join and frame math
// points load at one per cycle while in_ch.ready is high; the point marked last ends the frame
// after it both lanes sort at once (one sort per lane), then the merge join, the mean divide,
// the cordic heading and the drive commands follow in that order
// loading of the next frame overlaps the frame math of the previous one
// reset clears the point counts and loads the register defaults; stores are not cleared
module lane_center_steering_core #(
    parameter int MAX_POINTS   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lcs_in_if.sink      in_ch,
    lcs_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] T_LOAD  = 3'd0;
    localparam logic [2:0] T_START = 3'd1;
    localparam logic [2:0] T_SORT  = 3'd2;
    localparam logic [2:0] T_MRD   = 3'd3;
    localparam logic [2:0] T_MCMP  = 3'd4;
    localparam logic [2:0] T_MDONE = 3'd5;

    logic [2:0]    state_reg, state_next;
    lcs_pkg::cfg_t cfg_reg;
    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [CW-1:0] il_reg, il_next;
    logic [CW-1:0] ir_reg, ir_next;
    logic [lcs_pkg::CNT_W-1:0] n_reg, n_next;
    logic [lcs_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [lcs_pkg::Y_W-1:0]   ylast_reg, ylast_next;

    logic          accept;
    lcs_pkg::pt_t  pt;
    logic          l_we, r_we;
    logic          sort_start;
    logic          l_busy, r_busy;
    lcs_pkg::pt_t  l_q, r_q;
    logic [lcs_pkg::CNT_W-1:0] bottom;
    logic [11:0]   mid_sum;
    logic          calc_start, calc_busy;
    lcs_pkg::calc_req_t req;

    assign in_ch.ready = state_reg == T_LOAD;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        pt.y = in_ch.point_y;
        if (in_ch.point_x[11])
        begin
            pt.x = in_ch.lane_side ? cfg_reg.width_limit : 11'd0;
        end
        else
        begin
            pt.x = in_ch.point_x[10:0];
        end
        l_we = accept && !in_ch.lane_side && lc_reg < CW'(MAX_POINTS);
        r_we = accept && in_ch.lane_side && rc_reg < CW'(MAX_POINTS);
        if (cfg_reg.bottom_count == 5'd0)
        begin
            bottom = 5'd1;
        end
        else if (cfg_reg.bottom_count > 5'd16)
        begin
            bottom = 5'd16;
        end
        else
        begin
            bottom = cfg_reg.bottom_count;
        end
        mid_sum = {1'b0, l_q.x} + {1'b0, r_q.x};
        req.sum    = sum_reg;
        req.cnt    = n_reg;
        req.ylast  = ylast_reg;
        req.bottom = bottom;
    end

    always_comb
    begin
        state_next = state_reg;
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        il_next    = il_reg;
        ir_next    = ir_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        ylast_next = ylast_reg;
        sort_start = 1'b0;
        calc_start = 1'b0;
        unique case (state_reg)
            T_LOAD:
            begin
                if (l_we)
                begin
                    lc_next = lc_reg + 1'b1;
                end
                if (r_we)
                begin
                    rc_next = rc_reg + 1'b1;
                end
                if (accept && in_ch.frame_last)
                begin
                    state_next = T_START;
                end
            end
            T_START:
            begin
                sort_start = 1'b1;
                state_next = T_SORT;
            end
            T_SORT:
            begin
                il_next  = '0;
                ir_next  = '0;
                n_next   = '0;
                sum_next = '0;
                if (!l_busy && !r_busy)
                begin
                    state_next = T_MRD;
                end
            end
            T_MRD:
            begin
                if (il_reg < lc_reg && ir_reg < rc_reg && n_reg < bottom)
                begin
                    state_next = T_MCMP;
                end
                else
                begin
                    state_next = T_MDONE;
                end
            end
            T_MCMP:
            begin
                if (l_q.y == r_q.y)
                begin
                    sum_next   = sum_reg + lcs_pkg::SUM_W'(mid_sum[11:1]);
                    ylast_next = l_q.y;
                    n_next     = n_reg + 1'b1;
                    il_next    = il_reg + 1'b1;
                    ir_next    = ir_reg + 1'b1;
                end
                else if (l_q.y > r_q.y)
                begin
                    il_next = il_reg + 1'b1;
                end
                else
                begin
                    ir_next = ir_reg + 1'b1;
                end
                state_next = T_MRD;
            end
            T_MDONE:
            begin
                lc_next = '0;
                rc_next = '0;
                if (n_reg == '0)
                begin
                    state_next = T_LOAD;
                end
                else if (!calc_busy)
                begin
                    calc_start = 1'b1;
                    state_next = T_LOAD;
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_LOAD;
            lc_reg    <= '0;
            rc_reg    <= '0;
            cfg_reg.width_limit  <= 11'd639;
            cfg_reg.height_limit <= 10'd359;
            cfg_reg.bottom_count <= 5'd7;
            cfg_reg.max_linear   <= 15'd8192;
            cfg_reg.max_angular  <= 15'd16384;
            cfg_reg.steer_gain   <= 16'd728;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            rc_reg    <= rc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcs_pkg::CFG_WIDTH_LIMIT:  cfg_reg.width_limit  <= cfg_data[10:0];
                    lcs_pkg::CFG_HEIGHT_LIMIT: cfg_reg.height_limit <= cfg_data[9:0];
                    lcs_pkg::CFG_BOTTOM_COUNT: cfg_reg.bottom_count <= cfg_data[4:0];
                    lcs_pkg::CFG_MAX_LINEAR:   cfg_reg.max_linear   <= cfg_data[14:0];
                    lcs_pkg::CFG_MAX_ANGULAR:  cfg_reg.max_angular  <= cfg_data[14:0];
                    lcs_pkg::CFG_STEER_GAIN:   cfg_reg.steer_gain   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        il_reg    <= il_next;
        ir_reg    <= ir_next;
        n_reg     <= n_next;
        sum_reg   <= sum_next;
        ylast_reg <= ylast_next;
    end

    lcs_lane #(
        .MAX_POINTS (MAX_POINTS)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (l_we),
        .wr_addr (lc_reg[IW-1:0]),
        .wr_data (pt),
        .start   (sort_start),
        .count   (lc_reg),
        .busy    (l_busy),
        .rd_addr (il_reg[IW-1:0]),
        .rd_data (l_q)
    );

    lcs_lane #(
        .MAX_POINTS (MAX_POINTS)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (r_we),
        .wr_addr (rc_reg[IW-1:0]),
        .wr_data (pt),
        .start   (sort_start),
        .count   (rc_reg),
        .busy    (r_busy),
        .rd_addr (ir_reg[IW-1:0]),
        .rd_data (r_q)
    );

    lcs_calc #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (calc_start),
        .req    (req),
        .cfg    (cfg_reg),
        .busy   (calc_busy),
        .out_ch (out_ch)
    );

endmodule
